@@ src/stsum_pkg.sv @@
// ----------------------------------------------------------------------------
// stsum_pkg
// Shared constants, opcodes and sequencer state type for the range-sum tree.
// ----------------------------------------------------------------------------
`default_nettype none

package stsum_pkg;

  // tree geometry
  localparam int LEAVES      = 1024;
  localparam int LOG2_LEAVES = $clog2(LEAVES);
  localparam int MEM_DEPTH   = 2 * LEAVES;          // 1-based heap, entry 0 unused
  localparam int IDX_W       = LOG2_LEAVES + 1;     // node index width
  localparam int CNT_W       = IDX_W + 1;           // query bounds reach 2*LEAVES

  // item field widths
  localparam int POS_W  = 10;
  localparam int DATA_W = 64;

  // opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_UPD   = 4'b0100,
    ST_QRY   = 4'b1000
  } state_t;

endpackage

`default_nettype wire

@@ src/stsum_ram.sv @@
// ----------------------------------------------------------------------------
// stsum_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module stsum_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ src/segment_tree_range_sum_core.sv @@
// ----------------------------------------------------------------------------
// segment_tree_range_sum_core
// Point-update / range-sum segment tree held in one node memory.
// ----------------------------------------------------------------------------
// Usage
//   An item is taken at a rising edge with start high and busy low. in_op
//   selects a leaf write (in_position, in_value) or a range query
//   (in_range_low..in_range_high, inclusive). A write gives no result; a
//   query gives one result on out_range_sum, marked by out_valid for exactly
//   one cycle. The receiver cannot hold a result off.
//   Sums wrap modulo 2^64. An empty or reversed range gives 0; a high bound
//   past the last leaf is clipped; a write past the last leaf is dropped.
// Timing
//   A write walks the leaf-to-root path, one level per cycle, writing a
//   parent while reading the next sibling, and stays busy until the root
//   is written. A query makes at most one node read per cycle, with up to
//   two reads and a shift per level, and the result strobe comes in the
//   first cycle with busy low. The pace of both is set by the single read
//   port of the node memory.
// Reset
//   After reset the block sweeps every node entry to zero, one per cycle,
//   with busy high throughout.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_tree_range_sum_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic                                 in_op,
  input  wire logic        [stsum_pkg::POS_W-1:0]   in_position,
  input  wire logic signed [stsum_pkg::DATA_W-1:0]  in_value,
  input  wire logic        [stsum_pkg::POS_W-1:0]   in_range_low,
  input  wire logic        [stsum_pkg::POS_W-1:0]   in_range_high,
  output logic                                      out_valid,
  output logic signed      [stsum_pkg::DATA_W-1:0]  out_range_sum
);

  import stsum_pkg::*;

  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    clr_r, clr_nxt;
  logic [IDX_W-1:0]    node_r, node_nxt;
  logic [CNT_W-1:0]    a_r, a_nxt, b_r, b_nxt;
  logic [DATA_W-1:0]   acc_r, acc_nxt;
  logic                pend_r, pend_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]   out_sum_r, out_sum_nxt;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [DATA_W-1:0]   ram_wdata;
  logic [IDX_W-1:0]    ram_raddr;
  logic [DATA_W-1:0]   ram_rdata;

  logic                accept;
  logic                add_en;
  logic [DATA_W-1:0]   add_sum;
  logic [IDX_W-1:0]    leaf_idx;
  logic [IDX_W-1:0]    parent_idx;
  logic                pos_ok;
  logic                range_ok;
  logic [CNT_W-1:0]    hi_clip;
  logic [CNT_W-1:0]    b_dec;

  // node memory
  stsum_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MEM_DEPTH)
  ) u_nodes (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy          = (state_r != ST_IDLE);
  assign accept        = start && !busy;
  assign out_valid     = out_valid_r;
  assign out_range_sum = out_sum_r;

  // shared accumulator adder: sibling on the update walk, node on a query
  assign add_en  = (state_r == ST_UPD) || pend_r;
  assign add_sum = acc_r + (add_en ? ram_rdata : '0);

  // item decode
  assign pos_ok     = 32'(in_position) < LEAVES;
  assign leaf_idx   = IDX_W'(LEAVES) + IDX_W'(in_position);
  assign range_ok   = (in_range_low <= in_range_high) && (32'(in_range_low) < LEAVES);
  assign hi_clip    = (32'(in_range_high) >= LEAVES) ? CNT_W'(LEAVES - 1)
                                                     : CNT_W'(in_range_high);
  assign parent_idx = node_r >> 1;
  assign b_dec      = b_r - CNT_W'(1);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    node_nxt      = node_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    acc_nxt       = acc_r;
    pend_nxt      = 1'b0;
    out_valid_nxt = 1'b0;
    out_sum_nxt   = out_sum_r;
    ram_we        = 1'b0;
    ram_waddr     = parent_idx;
    ram_wdata     = add_sum;
    ram_raddr     = parent_idx ^ IDX_W'(1);

    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + IDX_W'(1);
        if (clr_r == IDX_W'(MEM_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          if (in_op == OP_QUERY) begin
            acc_nxt   = '0;
            state_nxt = ST_QRY;
            if (range_ok) begin
              a_nxt = CNT_W'(LEAVES) + CNT_W'(in_range_low);
              b_nxt = CNT_W'(LEAVES) + hi_clip + CNT_W'(1);
            end else begin
              a_nxt = '0;
              b_nxt = '0;
            end
          end else if (pos_ok) begin
            // write the leaf and fetch its sibling
            ram_we    = 1'b1;
            ram_waddr = leaf_idx;
            ram_wdata = in_value;
            ram_raddr = leaf_idx ^ IDX_W'(1);
            node_nxt  = leaf_idx;
            acc_nxt   = in_value;
            state_nxt = ST_UPD;
          end
        end
      end

      ST_UPD: begin
        // parent gets node plus sibling, then fetch the parent's sibling
        ram_we   = 1'b1;
        node_nxt = parent_idx;
        acc_nxt  = add_sum;
        if (parent_idx == IDX_W'(1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_QRY: begin
        acc_nxt = add_sum;
        if (a_r < b_r) begin
          priority if (a_r[0]) begin
            ram_raddr = a_r[IDX_W-1:0];
            pend_nxt  = 1'b1;
            a_nxt     = a_r + CNT_W'(1);
          end else if (b_r[0]) begin
            ram_raddr = b_dec[IDX_W-1:0];
            pend_nxt  = 1'b1;
            b_nxt     = b_dec;
          end else begin
            a_nxt = a_r >> 1;
            b_nxt = b_r >> 1;
          end
        end else begin
          out_valid_nxt = 1'b1;
          out_sum_nxt   = add_sum;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    node_r    <= node_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    acc_r     <= acc_nxt;
    out_sum_r <= out_sum_nxt;
  end

  // a result strobe only follows the last query cycle
  a_out_after_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_QRY))
    else $error("result strobe without a finishing query");

  // a pending read is only consumed while querying
  a_pend_in_query: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == ST_QRY))
    else $error("pending node read outside a query");

  // queries never modify the tree
  a_query_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_QRY) |-> !ram_we)
    else $error("node write during a query");

  // the update walk never sits on the root
  a_upd_below_root: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD) |-> (node_r != IDX_W'(1)))
    else $error("update walk passed the root");

  // query bounds never cross
  a_bounds_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_QRY) |-> (a_r <= b_r))
    else $error("query bounds crossed");

endmodule

`default_nettype wire
